@@ rtl/fsw_pkg.sv @@
// Shared types, widths and helpers for the full square window detector.
// No dependencies; used by the detector, its checkers and the testbench.
package fsw_pkg;

  localparam int unsigned RUN_W  = 10;
  localparam int unsigned DIM_W  = 10;
  localparam int unsigned TIME_W = 30;
  localparam int unsigned CFG_W  = 30;
  localparam int unsigned IDX_W  = 2;

  localparam logic [RUN_W-1:0] RUN_CAP = 10'd1023;

  typedef enum logic [IDX_W-1:0] {
    CFG_FRAME_ROWS  = 2'd0,
    CFG_FRAME_COLS  = 2'd1,
    CFG_WINDOW_SIZE = 2'd2,
    CFG_TIME_LIMIT  = 2'd3
  } cfg_index_t;

  typedef logic [RUN_W-1:0] run_t;

  // Saturating increment of a run count
  function automatic run_t run_inc(input run_t v);
    run_t r;
    if (v >= RUN_CAP) begin
      r = RUN_CAP;
    end else begin
      r = v + run_t'(1);
    end
    return r;
  endfunction

endpackage

@@ rtl/fsw_ram.sv @@
// Generic single-port-write, single-port-read RAM with registered read data.
// No dependencies.
module fsw_ram #(
  parameter int unsigned WIDTH = 10,
  parameter int unsigned DEPTH = 512
) (
  input  logic                                      clk,
  input  logic                                      we,
  input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] waddr,
  input  logic [WIDTH-1:0]                          wdata,
  input  logic                                      re,
  input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] raddr,
  output logic [WIDTH-1:0]                          rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

@@ rtl/full_square_window_detect.sv @@
// Full square window detector over a raster pixel stream.
// A result passes through stage one and then the output register after its
// pixel request is accepted.
// Throughput: one pixel per cycle while results are taken, set by the column-run RAM
// read-modify-write, which forwards a write to a read of the same column in the next pixel.
// Reset (rst, synchronous): clears control state, then sweeps every column of the
// column-run RAM to zero with s_tready low; config writes still land.
module full_square_window_detect #(
  parameter int unsigned MAX_ROWS = 512,
  parameter int unsigned MAX_COLS = 512
) (
  input  logic                      clk,
  input  logic                      rst,
  // configuration write port
  input  logic                      cfg_wen,
  input  logic [fsw_pkg::IDX_W-1:0] cfg_index,
  input  logic [fsw_pkg::CFG_W-1:0] cfg_wdata,
  // pixel stream in
  input  logic                      s_tvalid,
  output logic                      s_tready,
  input  logic [31:0]               s_tdata,  // [0] broken, [30:1] break_time, [31] zero
  input  logic                      s_tuser,  // [0] frame_start
  // result stream out
  output logic                      m_tvalid,
  input  logic                      m_tready,
  output logic [7:0]                m_tdata,  // [0] window_full, [1] found, [7:2] zero
  output logic                      m_tlast   // frame_done
);

  // Position and dimension widths follow the maxima; dimension compares are wide
  // enough for both the 10-bit register and the maximum itself.
  localparam int unsigned CW   = (MAX_COLS > 1) ? $clog2(MAX_COLS) : 1;
  localparam int unsigned RW   = (MAX_ROWS > 1) ? $clog2(MAX_ROWS) : 1;
  localparam int unsigned CDW  = ($clog2(MAX_COLS + 1) > 10) ? $clog2(MAX_COLS + 1) : 10;
  localparam int unsigned RDW  = ($clog2(MAX_ROWS + 1) > 10) ? $clog2(MAX_ROWS + 1) : 10;

  typedef logic [fsw_pkg::RUN_W-1:0] run_t;

  // Pixel state carried from the accept edge into the RAM-read stage
  typedef struct packed {
    logic [CW-1:0] col;
    logic          start;     // frame restart on this pixel
    logic          row_zero;  // no column run above this pixel
    logic          col_zero;  // horizontal run restarts here
    logic          set;
    logic          done;
    logic          fwd;       // column written by the previous pixel, use fwd_run
  } stage_t;

  // Configuration registers
  logic [fsw_pkg::DIM_W-1:0]  frame_rows;
  logic [fsw_pkg::DIM_W-1:0]  frame_cols;
  logic [fsw_pkg::DIM_W-1:0]  window_size;
  logic [fsw_pkg::TIME_W-1:0] time_limit;

  // Position and run state
  logic [RW-1:0] row_pos;
  logic [CW-1:0] col_pos;
  run_t          hrun;
  logic          found_reg;

  // RAM clearing sweep after reset
  logic          clearing;
  logic [CW-1:0] clr_addr;

  logic   s1_valid;
  stage_t s1;
  run_t   fwd_run;

  // Payload of the input request
  logic                      in_start;
  logic                      in_broken;
  logic [fsw_pkg::TIME_W-1:0] in_time;

  assign in_start  = s_tuser;
  assign in_broken = s_tdata[0];
  assign in_time   = s_tdata[30:1];

  // Handshake: the output register frees when empty or taken; stage one may
  // take a new pixel when it is empty or moving on and no sweep runs.
  logic advance;
  logic commit;
  logic accept;

  assign advance  = !m_tvalid || m_tready;
  assign commit   = s1_valid && advance;
  assign s_tready = !clearing && (!s1_valid || advance);
  assign accept   = s_tvalid && s_tready;

  // Effective frame dimensions: zero acts as one, above the maximum as the maximum
  logic [RDW-1:0] rows_eff;
  logic [CDW-1:0] cols_eff;

  always_comb begin
    if (frame_rows == '0) begin
      rows_eff = RDW'(1);
    end else if (RDW'(frame_rows) > RDW'(MAX_ROWS)) begin
      rows_eff = RDW'(MAX_ROWS);
    end else begin
      rows_eff = RDW'(frame_rows);
    end
    if (frame_cols == '0) begin
      cols_eff = CDW'(1);
    end else if (CDW'(frame_cols) > CDW'(MAX_COLS)) begin
      cols_eff = CDW'(MAX_COLS);
    end else begin
      cols_eff = CDW'(frame_cols);
    end
  end

  // Accept-side position logic: restart on frame_start, then test for the
  // last column and row of the frame.
  logic [RW-1:0] row_eff;
  logic [CW-1:0] col_eff;
  logic          last_col;
  logic          last_row;
  logic          pix_set;

  always_comb begin
    row_eff  = in_start ? '0 : row_pos;
    col_eff  = in_start ? '0 : col_pos;
    last_col = (CDW'(col_eff) + CDW'(1)) >= cols_eff;
    last_row = (RDW'(row_eff) + RDW'(1)) >= rows_eff;
    pix_set  = in_broken && (in_time <= time_limit);
  end

  // Column-run RAM: the sweep owns the write port until it ends
  logic          ram_we;
  logic [CW-1:0] ram_waddr;
  run_t          ram_wdata;
  run_t          ram_rdata;
  run_t          crun;

  assign ram_we    = clearing || commit;
  assign ram_waddr = clearing ? clr_addr : s1.col;
  assign ram_wdata = clearing ? '0 : crun;

  fsw_ram #(
    .WIDTH (fsw_pkg::RUN_W),
    .DEPTH (MAX_COLS)
  ) u_column_run (
    .clk   (clk),
    .we    (ram_we),
    .waddr (ram_waddr),
    .wdata (ram_wdata),
    .re    (accept),
    .raddr (col_eff),
    .rdata (ram_rdata)
  );

  // Stage one: extend the column run, then the horizontal run of columns
  // whose run reaches the window side; the window is full when that run does.
  run_t above;
  run_t hbase;
  run_t hrun_next;
  logic full;
  logic found_out;

  always_comb begin
    if (s1.row_zero) begin
      above = '0;
    end else if (s1.fwd) begin
      above = fwd_run;
    end else begin
      above = ram_rdata;
    end
    crun      = s1.set ? fsw_pkg::run_inc(above) : '0;
    hbase     = s1.col_zero ? '0 : hrun;
    hrun_next = (crun >= window_size) ? fsw_pkg::run_inc(hbase) : '0;
    full      = hrun_next >= window_size;
    found_out = (s1.start ? 1'b0 : found_reg) || full;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      frame_rows  <= 10'd512;
      frame_cols  <= 10'd512;
      window_size <= 10'd1;
      time_limit  <= '0;
      row_pos     <= '0;
      col_pos     <= '0;
      hrun        <= '0;
      found_reg   <= 1'b0;
      clearing    <= 1'b1;
      clr_addr    <= '0;
      s1_valid    <= 1'b0;
      m_tvalid    <= 1'b0;
    end else begin
      if (cfg_wen) begin
        case (fsw_pkg::cfg_index_t'(cfg_index))
          fsw_pkg::CFG_FRAME_ROWS:  frame_rows  <= cfg_wdata[fsw_pkg::DIM_W-1:0];
          fsw_pkg::CFG_FRAME_COLS:  frame_cols  <= cfg_wdata[fsw_pkg::DIM_W-1:0];
          fsw_pkg::CFG_WINDOW_SIZE: window_size <= cfg_wdata[fsw_pkg::DIM_W-1:0];
          fsw_pkg::CFG_TIME_LIMIT:  time_limit  <= cfg_wdata[fsw_pkg::TIME_W-1:0];
          default: ;
        endcase
      end

      // Advance the clearing sweep one column a cycle
      if (clearing) begin
        if (clr_addr == CW'(MAX_COLS - 1)) begin
          clearing <= 1'b0;
        end else begin
          clr_addr <= clr_addr + CW'(1);
        end
      end

      // Step the raster position on each accepted pixel
      if (accept) begin
        if (last_col) begin
          col_pos <= '0;
          row_pos <= last_row ? '0 : row_eff + RW'(1);
        end else begin
          col_pos <= col_eff + CW'(1);
          row_pos <= row_eff;
        end
      end

      // Fold the committed pixel into the run and found state
      if (commit) begin
        hrun      <= hrun_next;
        found_reg <= s1.done ? 1'b0 : found_out;
      end

      if (accept) begin
        s1_valid <= 1'b1;
      end else if (commit) begin
        s1_valid <= 1'b0;
      end

      if (advance) begin
        m_tvalid <= s1_valid;
      end
    end
  end

  // Payload registers: no reset needed
  always_ff @(posedge clk) begin
    if (accept) begin
      s1.col      <= col_eff;
      s1.start    <= in_start;
      s1.row_zero <= (row_eff == '0);
      s1.col_zero <= (col_eff == '0);
      s1.set      <= pix_set;
      s1.done     <= last_col && last_row;
      // the RAM misses a write landing on the same edge as the read
      s1.fwd      <= commit && (s1.col == col_eff);
      fwd_run     <= crun;
    end
    if (commit) begin
      m_tdata <= {6'd0, found_out, full};
      m_tlast <= s1.done;
    end
  end

endmodule

@@ rtl/fsw_checker.sv @@
// Port-level checker for the full square window detector, bound to its top level.
// Depends on fsw_pkg for the configuration port widths.
module fsw_checker (
  input logic                      clk,
  input logic                      rst,
  input logic                      cfg_wen,
  input logic [fsw_pkg::IDX_W-1:0] cfg_index,
  input logic [fsw_pkg::CFG_W-1:0] cfg_wdata,
  input logic                      s_tvalid,
  input logic                      s_tready,
  input logic [31:0]               s_tdata,
  input logic                      s_tuser,
  input logic                      m_tvalid,
  input logic                      m_tready,
  input logic [7:0]                m_tdata,
  input logic                      m_tlast
);

  // Requests accepted whose results are not yet taken
  logic [1:0] pending;
  logic       in_acc;
  logic       out_acc;

  assign in_acc  = s_tvalid && s_tready;
  assign out_acc = m_tvalid && m_tready;

  always_ff @(posedge clk) begin
    if (rst) begin
      pending <= '0;
    end else if (in_acc && !out_acc) begin
      pending <= pending + 2'd1;
    end else if (out_acc && !in_acc) begin
      pending <= pending - 2'd1;
    end
  end

  // Hold a stalled result
  a_out_hold: assert property (@(posedge clk) disable iff (rst)
    m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata) && $stable(m_tlast))
    else $error("stalled result changed or dropped");

  // Offer no result without an outstanding request
  a_no_invent: assert property (@(posedge clk) disable iff (rst)
    m_tvalid |-> pending != 2'd0)
    else $error("result without an accepted request");

  // Hold at most the stage and the output register in flight
  a_depth: assert property (@(posedge clk) disable iff (rst)
    pending != 2'd3)
    else $error("more requests in flight than pipeline stages");

  // Drop ready on leaving reset, when the column-run sweep starts
  a_sweep: assert property (@(posedge clk)
    rst |=> !s_tready)
    else $error("request taken during the clearing sweep");

endmodule

bind full_square_window_detect fsw_checker u_fsw_checker (
  .clk       (clk),
  .rst       (rst),
  .cfg_wen   (cfg_wen),
  .cfg_index (cfg_index),
  .cfg_wdata (cfg_wdata),
  .s_tvalid  (s_tvalid),
  .s_tready  (s_tready),
  .s_tdata   (s_tdata),
  .s_tuser   (s_tuser),
  .m_tvalid  (m_tvalid),
  .m_tready  (m_tready),
  .m_tdata   (m_tdata),
  .m_tlast   (m_tlast)
);

@@ dv/fsw_window_checker.sv @@
// Pixel-to-result checker for full_square_window_detect: tracks config writes,
// predicts each result from accepted pixel requests and compares the results.
// Depends on fsw_pkg for widths, the run type and the register index names.
module fsw_window_checker #(
  parameter int unsigned MAX_ROWS = 512,
  parameter int unsigned MAX_COLS = 512
) (
  input  logic                      clk,
  input  logic                      rst,
  input  logic                      cfg_wen,
  input  logic [fsw_pkg::IDX_W-1:0] cfg_index,
  input  logic [fsw_pkg::CFG_W-1:0] cfg_wdata,
  input  logic                      s_tvalid,
  input  logic                      s_tready,
  input  logic [31:0]               s_tdata,   // [0] broken, [30:1] break_time, [31] zero
  input  logic                      s_tuser,   // [0] frame_start
  input  logic                      m_tvalid,
  input  logic                      m_tready,
  input  logic [7:0]                m_tdata,   // [0] window_full, [1] found, [7:2] zero
  input  logic                      m_tlast,   // frame_done
  output int                        mismatch_count,
  output int                        results_owed
);
  timeunit 1ns;
  timeprecision 1ps;

  typedef struct packed {
    logic window_full;
    logic found;
    logic frame_done;
  } window_result_t;

  logic [fsw_pkg::DIM_W-1:0]  rows_reg;
  logic [fsw_pkg::DIM_W-1:0]  cols_reg;
  logic [fsw_pkg::DIM_W-1:0]  win_reg;
  logic [fsw_pkg::TIME_W-1:0] limit_reg;

  fsw_pkg::run_t column_run [MAX_COLS];
  int unsigned   row_pos;
  int unsigned   col_pos;
  fsw_pkg::run_t row_run;
  logic          found_flag;

  window_result_t expected_windows [$];
  window_result_t got;
  window_result_t want;
  int             fails = 0;

  // Runs stop counting once every bit is set
  function automatic fsw_pkg::run_t bump_run(input fsw_pkg::run_t v);
    return (v == '1) ? v : v + fsw_pkg::run_t'(1);
  endfunction

  function automatic int unsigned clamp_dim(input logic [fsw_pkg::DIM_W-1:0] v,
                                            input int unsigned top_v);
    if (v == '0) return 1;
    if (v > top_v) return top_v;
    return v;
  endfunction

  // Advance the pixel position and the runs by one pixel; return its result
  function automatic window_result_t next_window_result(input logic start, input logic brk,
                                                        input logic [fsw_pkg::TIME_W-1:0] bt);
    int unsigned    rows;
    int unsigned    cols;
    int unsigned    col;
    fsw_pkg::run_t  above;
    fsw_pkg::run_t  crun;
    logic           lit;
    logic           last_col;
    logic           last_row;
    window_result_t r;
    rows = clamp_dim(rows_reg, MAX_ROWS);
    cols = clamp_dim(cols_reg, MAX_COLS);
    if (start) begin
      row_pos    = 0;
      col_pos    = 0;
      row_run    = '0;
      found_flag = 1'b0;
    end
    if (col_pos == 0) row_run = '0;
    col = (col_pos >= MAX_COLS) ? MAX_COLS - 1 : col_pos;
    lit = brk && (bt <= limit_reg);
    // nothing lies above the top row, whatever the column store still holds
    above = (row_pos == 0) ? '0 : column_run[col];
    crun = lit ? bump_run(above) : '0;
    column_run[col] = crun;
    if (crun >= win_reg) begin
      row_run = bump_run(row_run);
    end else begin
      row_run = '0;
    end
    r.window_full = (row_run >= win_reg);
    if (r.window_full) found_flag = 1'b1;
    r.found = found_flag;
    last_col = (col_pos + 1 >= cols);
    last_row = (row_pos + 1 >= rows);
    r.frame_done = last_col && last_row;
    if (last_col) begin
      col_pos = 0;
      row_run = '0;
      if (last_row) begin
        row_pos    = 0;
        found_flag = 1'b0;
      end else begin
        row_pos = row_pos + 1;
      end
    end else begin
      col_pos = col_pos + 1;
    end
    return r;
  endfunction

  function automatic void check_field(input string field, input logic exp_v, input logic act_v);
    if (exp_v !== act_v) begin
      $display("%0t ns: %s mismatch, expected %b, actual %b", $time, field, exp_v, act_v);
      fails++;
    end
  endfunction

  always @(posedge clk) begin
    if (rst) begin
      rows_reg   = 10'd512;
      cols_reg   = 10'd512;
      win_reg    = 10'd1;
      limit_reg  = '0;
      row_pos    = 0;
      col_pos    = 0;
      row_run    = '0;
      found_flag = 1'b0;
      foreach (column_run[i]) column_run[i] = '0;
      expected_windows.delete();
    end else begin
      if (cfg_wen) begin
        case (cfg_index)
          fsw_pkg::CFG_FRAME_ROWS:  rows_reg  = cfg_wdata[fsw_pkg::DIM_W-1:0];
          fsw_pkg::CFG_FRAME_COLS:  cols_reg  = cfg_wdata[fsw_pkg::DIM_W-1:0];
          fsw_pkg::CFG_WINDOW_SIZE: win_reg   = cfg_wdata[fsw_pkg::DIM_W-1:0];
          fsw_pkg::CFG_TIME_LIMIT:  limit_reg = cfg_wdata[fsw_pkg::TIME_W-1:0];
          default: ;
        endcase
      end
      if (s_tvalid && s_tready) begin
        expected_windows.insert(expected_windows.size(),
                                next_window_result(s_tuser, s_tdata[0],
                                                   s_tdata[fsw_pkg::TIME_W:1]));
      end
      if (m_tvalid && m_tready) begin
        got.window_full = m_tdata[0];
        got.found       = m_tdata[1];
        got.frame_done  = m_tlast;
        if (expected_windows.size() == 0) begin
          $display("%0t ns: unexpected result, expected none, actual %b", $time, got);
          fails++;
        end else begin
          want = expected_windows.pop_front();
          check_field("window_full", want.window_full, got.window_full);
          check_field("found", want.found, got.found);
          check_field("frame_done", want.frame_done, got.frame_done);
        end
      end
    end
    results_owed   <= expected_windows.size();
    mismatch_count <= fails;
  end

endmodule

@@ dv/testbench.sv @@
// Top of the full_square_window_detect test: clock, reset, pixel requests,
// result back-pressure and the verdict. Depends on fsw_pkg, the block and
// fsw_window_checker, which predicts and compares every result.
module testbench;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int unsigned MAX_ROWS     = 512;
  localparam int unsigned MAX_COLS     = 512;
  localparam int unsigned RANDOM_ITEMS = 1850;
  // longest quiet stretch is the reset sweep of the column store; allow plenty
  localparam int unsigned QUIET_LIMIT  = 6000;
  localparam logic [fsw_pkg::TIME_W-1:0] TIME_MAX = '1;

  typedef enum int {
    RX_ALWAYS,
    RX_COIN,
    RX_MOSTLY,
    RX_LONG_STALLS
  } rx_mode_t;

  logic                       clk = 1'b0;
  logic                       rst;
  logic                       cfg_wen;
  logic [fsw_pkg::IDX_W-1:0]  cfg_index;
  logic [fsw_pkg::CFG_W-1:0]  cfg_wdata;
  logic                       s_tvalid;
  logic                       s_tready;
  logic [31:0]                s_tdata;   // [0] broken, [30:1] break_time, [31] zero
  logic                       s_tuser;   // [0] frame_start
  logic                       m_tvalid;
  logic                       m_tready;
  logic [7:0]                 m_tdata;   // [0] window_full, [1] found, [7:2] zero
  logic                       m_tlast;   // frame_done

  int                         mismatch_count;
  int                         results_owed;

  // sender state: requests left in the current burst, and the time limit in force
  int unsigned                burst_left = 0;
  logic [fsw_pkg::TIME_W-1:0] cur_tlim   = '0;

  // receiver state
  rx_mode_t                   rx_mode    = RX_ALWAYS;
  int unsigned                rx_cycle   = 0;
  int unsigned                stall_left = 0;

  int unsigned                quiet_cycles = 0;

  always begin
    #2 clk = 1'b1;
    #2 clk = 1'b0;
  end

  full_square_window_detect #(
    .MAX_ROWS (MAX_ROWS),
    .MAX_COLS (MAX_COLS)
  ) i_dut (
    .clk       (clk),
    .rst       (rst),
    .cfg_wen   (cfg_wen),
    .cfg_index (cfg_index),
    .cfg_wdata (cfg_wdata),
    .s_tvalid  (s_tvalid),
    .s_tready  (s_tready),
    .s_tdata   (s_tdata),
    .s_tuser   (s_tuser),
    .m_tvalid  (m_tvalid),
    .m_tready  (m_tready),
    .m_tdata   (m_tdata),
    .m_tlast   (m_tlast)
  );

  fsw_window_checker #(
    .MAX_ROWS (MAX_ROWS),
    .MAX_COLS (MAX_COLS)
  ) i_checker (
    .clk            (clk),
    .rst            (rst),
    .cfg_wen        (cfg_wen),
    .cfg_index      (cfg_index),
    .cfg_wdata      (cfg_wdata),
    .s_tvalid       (s_tvalid),
    .s_tready       (s_tready),
    .s_tdata        (s_tdata),
    .s_tuser        (s_tuser),
    .m_tvalid       (m_tvalid),
    .m_tready       (m_tready),
    .m_tdata        (m_tdata),
    .m_tlast        (m_tlast),
    .mismatch_count (mismatch_count),
    .results_owed   (results_owed)
  );

  // Receiver back-pressure: switch between random styles of stall so that
  // stalls land on every phase of the pipeline, with spells of none.
  always @(posedge clk) begin
    if (rx_cycle % 300 == 0) rx_mode = rx_mode_t'($urandom_range(0, 3));
    rx_cycle++;
    case (rx_mode)
      RX_ALWAYS: m_tready <= 1'b1;
      RX_COIN:   m_tready <= 1'($urandom_range(0, 1));
      RX_MOSTLY: m_tready <= ($urandom_range(0, 9) != 0);
      default: begin
        if (stall_left != 0) begin
          stall_left--;
          m_tready <= 1'b0;
        end else begin
          m_tready <= 1'b1;
          if ($urandom_range(0, 7) == 0) stall_left = $urandom_range(1, 30);
        end
      end
    endcase
  end

  // Watchdog: end the run if nothing moves on either side for too long
  always @(posedge clk) begin
    if ((s_tvalid && s_tready) || (m_tvalid && m_tready)) begin
      quiet_cycles <= 0;
    end else if (quiet_cycles >= QUIET_LIMIT) begin
      $display("full_square_window_detect test failed");
      $finish;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
  end

  // Effective frame dimension: zero acts as one, oversize acts as the maximum
  function automatic int unsigned frame_dim(input int unsigned v, input int unsigned top_v);
    if (v % 1024 == 0) return 1;
    if (v % 1024 > top_v) return top_v;
    return v % 1024;
  endfunction

  // Dimension register value with random junk above the register width
  function automatic logic [fsw_pkg::CFG_W-1:0] pad_dim(input int unsigned v);
    logic [fsw_pkg::CFG_W-fsw_pkg::DIM_W-1:0] junk;
    junk = $urandom_range(0, 1) ? (fsw_pkg::CFG_W-fsw_pkg::DIM_W)'($urandom) : '0;
    return {junk, fsw_pkg::DIM_W'(v)};
  endfunction

  // Offer one pixel request and hold it until accepted. Bursts of random
  // length are separated by random gaps; valid stays high across a burst.
  task automatic send_pixel(input logic start, input logic brk,
                            input logic [fsw_pkg::TIME_W-1:0] bt);
    int unsigned gap;
    if (burst_left == 0) begin
      gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 24);
      if (gap != 0) begin
        s_tvalid <= 1'b0;
        repeat (gap) @(posedge clk);
      end
      burst_left = ($urandom_range(0, 9) == 0) ? $urandom_range(50, 300) : $urandom_range(1, 12);
    end
    s_tvalid <= 1'b1;
    s_tuser  <= start;
    s_tdata  <= {1'b0, bt, brk};
    @(posedge clk);
    while (!s_tready) @(posedge clk);
    burst_left--;
  endtask

  // Pixel that is set or not under the current time limit, with random content
  task automatic send_random_pixel(input logic start, input bit want_set);
    logic                       brk;
    logic [fsw_pkg::TIME_W-1:0] bt;
    if (want_set) begin
      brk = 1'b1;
      bt  = fsw_pkg::TIME_W'($urandom_range(0, cur_tlim));
    end else if (cur_tlim == TIME_MAX || $urandom_range(0, 1)) begin
      brk = 1'b0;
      bt  = fsw_pkg::TIME_W'($urandom);
    end else begin
      brk = 1'b1;
      bt  = fsw_pkg::TIME_W'($urandom_range(cur_tlim + 1, TIME_MAX));
    end
    send_pixel(start, brk, bt);
  endtask

  // Drop valid and wait until every result owed has come back and the
  // pipeline has drained, so that a register write finds the block idle.
  task automatic settle();
    s_tvalid <= 1'b0;
    @(posedge clk);
    while (results_owed != 0) @(posedge clk);
    repeat (4) @(posedge clk);
  endtask

  // Write all four registers on consecutive cycles
  task automatic set_regs(input int unsigned rows, input int unsigned cols,
                          input int unsigned win, input logic [fsw_pkg::TIME_W-1:0] tlim);
    cfg_wen   <= 1'b1;
    cfg_index <= fsw_pkg::CFG_FRAME_ROWS;
    cfg_wdata <= pad_dim(rows);
    @(posedge clk);
    cfg_index <= fsw_pkg::CFG_FRAME_COLS;
    cfg_wdata <= pad_dim(cols);
    @(posedge clk);
    cfg_index <= fsw_pkg::CFG_WINDOW_SIZE;
    cfg_wdata <= pad_dim(win);
    @(posedge clk);
    cfg_index <= fsw_pkg::CFG_TIME_LIMIT;
    cfg_wdata <= fsw_pkg::CFG_W'(tlim);
    @(posedge clk);
    cfg_wen   <= 1'b0;
    cur_tlim  = tlim;
  endtask

  initial begin
    int unsigned phase;
    int unsigned sent;
    int unsigned rows;
    int unsigned cols;
    int unsigned win;
    int unsigned density;
    int unsigned nframes;
    int unsigned len;
    int unsigned pick;
    bit          big;
    logic        lead;
    logic [fsw_pkg::TIME_W-1:0] tlim;

    rst       <= 1'b1;
    cfg_wen   <= 1'b0;
    cfg_index <= fsw_pkg::CFG_FRAME_ROWS;
    cfg_wdata <= '0;
    s_tvalid  <= 1'b0;
    s_tdata   <= '0;
    s_tuser   <= 1'b0;
    repeat (8) @(posedge clk);
    rst <= 1'b0;
    settle();

    // 2x3 frame, window 2: set at the limit, just above it and at zero, and a
    // pixel that never breaks at the top of the time range
    set_regs(2, 3, 2, 30'd100);
    send_pixel(1'b1, 1'b1, 30'd0);
    send_pixel(1'b0, 1'b1, 30'd100);
    send_pixel(1'b0, 1'b1, 30'd101);
    send_pixel(1'b0, 1'b1, 30'd50);
    send_pixel(1'b0, 1'b1, 30'd100);
    send_pixel(1'b0, 1'b0, TIME_MAX);
    settle();

    // zero frame size acts as 1x1; frames wrap with no frame_start
    set_regs(0, 0, 1, TIME_MAX);
    send_pixel(1'b0, 1'b1, TIME_MAX);
    send_pixel(1'b0, 1'b0, 30'd0);
    send_pixel(1'b1, 1'b1, 30'd5);
    settle();

    // zero window: every pixel is full, set or not
    set_regs(2, 2, 0, 30'd0);
    send_pixel(1'b1, 1'b0, TIME_MAX);
    send_pixel(1'b0, 1'b1, 30'd1);
    send_pixel(1'b0, 1'b0, 30'd0);
    send_pixel(1'b0, 1'b1, 30'd0);
    settle();

    // window larger than the frame: never full
    set_regs(2, 2, 3, TIME_MAX);
    for (int i = 0; i < 4; i++) send_pixel(i == 0, 1'b1, 30'd0);
    settle();

    // shrink the geometry in mid-frame: the position beyond the new last
    // column wraps at once, then the row beyond the new last row ends the frame
    set_regs(4, 5, 1, 30'd50);
    for (int i = 0; i < 7; i++) send_pixel(i == 0, 1'b1, (i == 3) ? 30'd51 : 30'(i * 7));
    settle();
    set_regs(4, 2, 1, 30'd50);
    for (int i = 0; i < 3; i++) send_pixel(1'b0, 1'b1, 30'd10);
    settle();
    set_regs(1, 2, 1, 30'd50);
    send_pixel(1'b0, 1'b1, 30'd50);
    send_pixel(1'b0, 1'b1, 30'd49);
    settle();

    // Random phases: mostly whole frames led by frame_start, with truncated
    // frames, stray frame_starts and phases that open mid-frame as noise.
    // Two phases use oversize dimensions, kept to a single row or column.
    phase = 0;
    sent  = 0;
    while (sent < RANDOM_ITEMS) begin
      big = (phase == 2) || (phase == 5);
      if (phase == 2) begin
        rows = $urandom_range(513, 1023);
        cols = $urandom_range(0, 1);
        win  = $urandom_range(0, 1);
      end else if (phase == 5) begin
        rows = $urandom_range(0, 1);
        cols = $urandom_range(513, 1023);
        win  = $urandom_range(0, 2);
      end else begin
        rows = $urandom_range(0, 10);
        cols = $urandom_range(0, 14);
        pick = $urandom_range(0, 9);
        if (pick == 0) win = 0;
        else if (pick == 1) win = $urandom_range(11, 1023);
        else win = $urandom_range(1, 4);
      end
      pick = $urandom_range(0, 5);
      if (pick == 0) tlim = '0;
      else if (pick == 1) tlim = TIME_MAX;
      else tlim = fsw_pkg::TIME_W'($urandom_range(0, TIME_MAX));

      settle();
      set_regs(rows, cols, win, tlim);
      density = $urandom_range(55, 97);
      nframes = big ? 1 : $urandom_range(1, 4);
      for (int f = 0; f < nframes; f++) begin
        len = frame_dim(rows, MAX_ROWS) * frame_dim(cols, MAX_COLS);
        if (!big && len > 1 && $urandom_range(0, 6) == 0) len = $urandom_range(1, len - 1);
        lead = (f == 0) ? ($urandom_range(0, 4) != 0) : ($urandom_range(0, 2) == 0);
        for (int p = 0; p < len; p++) begin
          send_random_pixel((p == 0) ? lead : ($urandom_range(0, 99) == 0),
                            $urandom_range(1, 100) <= density);
          sent++;
        end
      end
      // carry the oversize frames past their end to see the wrap
      if (big) begin
        for (int p = 0; p < 3; p++) send_random_pixel(1'b0, 1'($urandom_range(0, 1)));
        sent += 3;
      end
      phase++;
    end

    settle();
    repeat (8) @(posedge clk);
    if (mismatch_count == 0 && results_owed == 0) begin
      $display("full_square_window_detect test passed");
    end else begin
      $display("full_square_window_detect test failed");
    end
    $finish;
  end

endmodule

@@ files.f @@
rtl/fsw_pkg.sv
rtl/fsw_ram.sv
rtl/full_square_window_detect.sv
rtl/fsw_checker.sv
dv/fsw_window_checker.sv
dv/testbench.sv
